// File: design/dqd_pkg.sv
// Shared constants for the double-ended queue with delete.
package dqd_pkg;

  localparam int DQD_DEPTH      = 16;
  localparam int DQD_DATA_WIDTH = 32;

  localparam int REQ_W  = 3;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DELETE     = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

// File: design/double_ended_queue_with_delete_top.sv
// Bounded double-ended queue with first-match delete, ring buffer in one memory.
// Pushes, unknown requests and requests on an empty queue raise done from the dispatch
// state; other pops from a further output state, and other deletes after a scan through
// the single read port (read, compare per entry) and any gap close (read, write per move).
// busy is high from the accept edge until the result cycle; the receiver cannot stall.
// Synchronous active-high rst empties the queue; slot contents are not cleared.
module double_ended_queue_with_delete_top
  import dqd_pkg::*;
#(
  parameter int DEPTH      = DQD_DEPTH,
  parameter int DATA_WIDTH = DQD_DATA_WIDTH,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [REQ_W-1:0]        req_type,
  input  logic signed [VAL_W-1:0] value,
  output logic                    done,
  output logic signed [VAL_W-1:0] popped,
  output logic [CNT_W-1:0]        entries,
  output logic [STAT_W-1:0]       status
);

  localparam int CW = CNT_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP_OUT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_t;

  state_t                  state;
  logic [REQ_W-1:0]        req;
  logic [DATA_WIDTH-1:0]   word;
  logic [AW-1:0]           front;
  logic [CNT_W-1:0]        held;
  logic [AW-1:0]           idx;

  logic [DATA_WIDTH-1:0]   mem [DEPTH];
  logic [DATA_WIDTH-1:0]   rd_data;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [DATA_WIDTH-1:0]   wr_data;

  logic signed [63:0]            val_ext;
  logic signed [DATA_WIDTH-1:0]  rd_signed;
  logic signed [63:0]            rd_ext;
  logic [CW-1:0]                 idx_inc;
  logic [CW-1:0]                 idx_inc2;
  logic [CW-1:0]                 held_w;
  logic                          is_empty;
  logic                          is_full;

  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign val_ext   = 64'(value);
  assign rd_signed = rd_data;
  assign rd_ext    = 64'(rd_signed);
  assign idx_inc   = CW'(idx) + CW'(1);
  assign idx_inc2  = CW'(idx) + CW'(2);
  assign held_w    = CW'(held);
  assign is_empty  = (held == '0);
  assign is_full   = (held_w >= CW'(DEPTH));
  assign busy      = (state != S_IDLE);

  // memory port control
  always_comb begin
    rd_addr = ring_pos(front, idx);
    wr_en   = 1'b0;
    wr_addr = ring_pos(front, idx);
    wr_data = rd_data;
    case (state)
      S_DISPATCH: begin
        case (req)
          REQ_PUSH_BACK: begin
            wr_en   = !is_full;
            wr_addr = ring_pos(front, AW'(held));
            wr_data = word;
          end
          REQ_PUSH_FRONT: begin
            wr_en   = !is_full;
            wr_addr = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
            wr_data = word;
          end
          REQ_POP_BACK:  rd_addr = ring_pos(front, AW'(held - CNT_W'(1)));
          REQ_POP_FRONT: rd_addr = front;
          default:       rd_addr = front;
        endcase
      end
      S_SHIFT_RD: rd_addr = ring_pos(front, idx + AW'(1));
      S_SHIFT_WR: wr_en   = 1'b1;
      default:    rd_addr = ring_pos(front, idx);
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      front   <= '0;
      held    <= '0;
      idx     <= '0;
      done    <= 1'b0;
      popped  <= '0;
      entries <= '0;
      status  <= ST_OK;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req   <= req_type;
            word  <= val_ext[DATA_WIDTH-1:0];
            idx   <= '0;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          popped <= '0;
          status <= ST_OK;
          state  <= S_IDLE;
          case (req)
            REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
              done <= 1'b1;
              if (is_full) begin
                status  <= ST_FULL;
                entries <= held;
              end else begin
                if (req == REQ_PUSH_FRONT) begin
                  front <= (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
                end
                held    <= held + CNT_W'(1);
                entries <= held + CNT_W'(1);
              end
            end
            REQ_POP_BACK, REQ_POP_FRONT: begin
              if (is_empty) begin
                done    <= 1'b1;
                status  <= ST_EMPTY;
                entries <= held;
              end else begin
                if (req == REQ_POP_FRONT) begin
                  front <= (front == AW'(DEPTH - 1)) ? '0 : front + AW'(1);
                end
                held  <= held - CNT_W'(1);
                state <= S_POP_OUT;
              end
            end
            REQ_DELETE: begin
              if (is_empty) begin
                done    <= 1'b1;
                status  <= ST_NOTFOUND;
                entries <= held;
              end else begin
                state <= S_SCAN_RD;
              end
            end
            default: begin
              done    <= 1'b1;
              entries <= held;
            end
          endcase
        end
        S_POP_OUT: begin
          done    <= 1'b1;
          popped  <= rd_ext[VAL_W-1:0];
          entries <= held;
          state   <= S_IDLE;
        end
        S_SCAN_RD: state <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (rd_data == word) begin
            // first match: move later entries up, or just drop the last one
            if (idx_inc < held_w) begin
              state <= S_SHIFT_RD;
            end else begin
              held    <= held - CNT_W'(1);
              entries <= held - CNT_W'(1);
              done    <= 1'b1;
              state   <= S_IDLE;
            end
          end else if (idx_inc < held_w) begin
            idx   <= idx + AW'(1);
            state <= S_SCAN_RD;
          end else begin
            status  <= ST_NOTFOUND;
            entries <= held;
            done    <= 1'b1;
            state   <= S_IDLE;
          end
        end
        S_SHIFT_RD: state <= S_SHIFT_WR;
        S_SHIFT_WR: begin
          idx <= idx + AW'(1);
          if (idx_inc2 < held_w) begin
            state <= S_SHIFT_RD;
          end else begin
            held    <= held - CNT_W'(1);
            entries <= held - CNT_W'(1);
            done    <= 1'b1;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: tb/tb_double_ended_queue_with_delete_top.sv
// Testbench for the double-ended queue with first-match delete: directed and random requests.
module tb_double_ended_queue_with_delete_top
  import dqd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int D          = DQD_DEPTH;
  localparam int CNT_W      = $clog2(DQD_DEPTH + 1);
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic signed [VAL_W-1:0] popped;
    logic [CNT_W-1:0]        entries;
    logic [STAT_W-1:0]       status;
  } deque_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic [REQ_W-1:0]        req_type = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic                    busy;
  logic                    done;
  logic signed [VAL_W-1:0] popped;
  logic [CNT_W-1:0]        entries;
  logic [STAT_W-1:0]       status;

  // Mirror of the queue contents
  logic signed [VAL_W-1:0] mirror_slot [D];
  int                      mirror_front = 0;
  int                      mirror_count = 0;

  deque_result_t pending_results[$];
  int            error_count = 0;
  int            idle_cycles = 0;
  bit            no_idle = 1'b0;

  double_ended_queue_with_delete_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req_type (req_type),
    .value    (value),
    .done     (done),
    .popped   (popped),
    .entries  (entries),
    .status   (status)
  );

  always #5 clk = ~clk;

  task automatic deque_apply(input logic [REQ_W-1:0] rt, input logic signed [VAL_W-1:0] v,
                             output deque_result_t res);
    int k;
    bit found;
    res = '0;
    case (rt)
      REQ_PUSH_BACK: begin
        if (mirror_count >= D) begin
          res.status = ST_FULL;
        end else begin
          mirror_slot[(mirror_front + mirror_count) % D] = v;
          mirror_count++;
        end
      end
      REQ_POP_BACK: begin
        if (mirror_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.popped = mirror_slot[(mirror_front + mirror_count - 1) % D];
          mirror_count--;
        end
      end
      REQ_PUSH_FRONT: begin
        if (mirror_count >= D) begin
          res.status = ST_FULL;
        end else begin
          mirror_front = (mirror_front + D - 1) % D;
          mirror_slot[mirror_front] = v;
          mirror_count++;
        end
      end
      REQ_POP_FRONT: begin
        if (mirror_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.popped = mirror_slot[mirror_front];
          mirror_front = (mirror_front + 1) % D;
          mirror_count--;
        end
      end
      REQ_DELETE: begin
        found = 1'b0;
        for (k = 0; k < mirror_count; k++) begin
          if (mirror_slot[(mirror_front + k) % D] == v) begin
            found = 1'b1;
            break;
          end
        end
        if (!found) begin
          res.status = ST_NOTFOUND;
        end else begin
          // close the gap behind the removed entry
          for (int j = k; j + 1 < mirror_count; j++)
            mirror_slot[(mirror_front + j) % D] = mirror_slot[(mirror_front + j + 1) % D];
          mirror_count--;
        end
      end
      default: ;
    endcase
    res.entries = CNT_W'(mirror_count);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] rt, input logic signed [VAL_W-1:0] v);
    int gap;
    deque_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    req_type <= rt;
    value    <= v;
    do @(posedge clk); while (busy !== 1'b0);
    deque_apply(rt, v, res);
    pending_results.push_back(res);
  endtask

  task automatic compare_field(input string name, input logic [VAL_W-1:0] exp_val,
                               input logic [VAL_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name,
               $signed(exp_val), $signed(act_val));
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    deque_result_t exp_res;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request pending: popped %0d entries %0d status %0d",
                 $time, popped, entries, status);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        compare_field("popped", exp_res.popped, popped);
        compare_field("entries", VAL_W'(exp_res.entries), VAL_W'(entries));
        compare_field("status", VAL_W'(exp_res.status), VAL_W'(status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [VAL_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return 32'sd1;
      5: return 32'sd42;
      6: return 32'sh5555_5555;
      7: return 32'shaaaa_aaaa;
      8, 9: return 32'sd7;
      default: return $urandom();
    endcase
  endfunction

  // Mostly pick a value that is held, so deletes reach the compaction path
  function automatic logic signed [VAL_W-1:0] pick_delete_word();
    if (mirror_count > 0 && $urandom_range(0, 99) < 70)
      return mirror_slot[(mirror_front + $urandom_range(0, mirror_count - 1)) % D];
    return pick_word();
  endfunction

  task automatic test_empty_queue();
    send_request(REQ_POP_BACK, 32'sd0);
    send_request(REQ_POP_FRONT, -32'sd1);
    send_request(REQ_DELETE, 32'sd0);
    send_request(3'd7, 32'sh7fff_ffff);
  endtask

  task automatic test_full_queue();
    for (int i = 0; i < D; i++) begin
      case (i % 4)
        0: send_request(REQ_PUSH_BACK, 32'sh8000_0000);
        1: send_request(REQ_PUSH_FRONT, 32'sh7fff_ffff);
        2: send_request(REQ_PUSH_BACK, -32'sd1);
        default: send_request(REQ_PUSH_FRONT, 32'sd0);
      endcase
    end
    send_request(REQ_PUSH_BACK, 32'sd5);
    send_request(REQ_PUSH_FRONT, 32'sd6);
  endtask

  task automatic test_delete_and_pops();
    // several matches: only the one nearest the front goes
    send_request(REQ_DELETE, -32'sd1);
    send_request(REQ_DELETE, 32'sd123);
    send_request(REQ_POP_FRONT, 32'sd0);
    send_request(REQ_POP_BACK, 32'sd0);
  endtask

  task automatic test_random_mix(input int n_items);
    int mode, r, push_w, del_w;
    logic [REQ_W-1:0] rt;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        mode    = $urandom_range(0, 3);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      case (mode)
        0:       begin push_w = 75; del_w = 10; end
        1:       begin push_w = 20; del_w = 10; end
        2:       begin push_w = 45; del_w = 15; end
        default: begin push_w = 30; del_w = 40; end
      endcase
      r = $urandom_range(0, 99);
      if (r < 2) begin
        rt = REQ_W'($urandom_range(5, 7));
        send_request(rt, pick_word());
      end else if (r < 2 + push_w) begin
        send_request($urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, pick_word());
      end else if (r < 2 + push_w + del_w) begin
        send_request(REQ_DELETE, pick_delete_word());
      end else begin
        send_request($urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT, pick_word());
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty_queue();
    test_full_queue();
    test_delete_and_pops();
    test_random_mix(1520);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
